// ----- design/lanczos_image_upscaler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Lanczos image upscaler
// Shared property shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LANCZOS_IMAGE_UPSCALER_MACROS_SVH
`define LANCZOS_IMAGE_UPSCALER_MACROS_SVH

// Same-cycle implication.
`define LCZ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lanczos upscaler: same-cycle property failed");

// Next-cycle implication.
`define LCZ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lanczos upscaler: next-cycle property failed");

`endif

// ----- design/lcz_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos upscaler package
// Transfer types, sequencer states and fixed datapath widths.
// ----------------------------------------------------------------------------
package lcz_pkg;

   localparam int POS_W = 10;   // scaled source position, up to 127 * 8
   localparam int IDX_W = 10;   // tap index into a row or a column
   localparam int D_W   = 14;   // signed tap offset
   localparam int WGT_W = 16;   // Q2.14 weight
   localparam int ACC_W = 28;   // per-pass accumulator

   localparam bit [63:0] PI_Q30 = 64'd3373259426;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef struct packed {
      logic       command;
      logic [6:0] pix_row;
      logic [6:0] pix_col;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       bad_coord;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_HTAP,
      ST_HDRAIN,
      ST_VACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic hclear;
      logic hacc;
      logic vclear;
      logic vacc;
   } mac_ctrl_type;

   typedef struct packed {
      logic [IDX_W-1:0]      lo;
      logic [IDX_W-1:0]      hi;
      logic signed [D_W-1:0] d0;
   } range_type;

endpackage

// ----- design/lanczos_image_upscaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos image upscaler
// Holds an input RGB image and returns pixels of the upscaled image, filtered
// by a separable Lanczos kernel on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   lcz_pkg::req_type (write or read)
//   rsp_      out        rsp_valid/rsp_ready   lcz_pkg::rsp_type (one per read)
//
// A write transfer leaves the block idle and ready for the next request.
// A read runs setup, then for every source row a horizontal tap loop, a drain
// step and a vertical accumulate step, then holds its result. Each pass spans
// up to 2 * KERNEL_A taps, a single tap with the coordinate on the grid, and a
// coordinate outside the output image skips the filter.
// The rate is set by the single image store read port and the shared MAC.
// The result is held until its transfer completes; no request is taken meanwhile.
// Reset is synchronous and clears only the sequencer; the image store is not
// cleared and a never-written pixel reads as an arbitrary value.
//
`include "lanczos_image_upscaler_macros.svh"

module lanczos_image_upscaler #(
   parameter int IN_W      = 64,
   parameter int IN_H      = 64,
   parameter int KERNEL_A  = 3,
   parameter int SCALE_NUM = 2,
   parameter int SCALE_DEN = 1,
   parameter int CHANNELS  = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcz_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcz_pkg::rsp_type  rsp_data
);

   localparam int OUT_W    = (IN_W * SCALE_NUM) / SCALE_DEN;
   localparam int OUT_H    = (IN_H * SCALE_NUM) / SCALE_DEN;
   localparam bit WHOLE_RATIO = (SCALE_NUM % SCALE_DEN) == 0;
   localparam int TAP_SPAN = KERNEL_A * SCALE_NUM;
   localparam int TAB_W    = $clog2(TAP_SPAN + 1);
   localparam int DEPTH    = IN_W * IN_H;
   localparam int ADDR_W   = $clog2(DEPTH);
   // Floor division of a position by SCALE_NUM through a reciprocal; exact
   // for every position below 1024.
   localparam int RECIP_SH = 16;
   localparam int RECIP    = ((1 << RECIP_SH) + SCALE_NUM - 1) / SCALE_NUM;
   localparam logic [23:0] CH_MASK = {{8{CHANNELS >= 1}}, {8{CHANNELS >= 2}},
                                      {8{CHANNELS >= 3}}};

   // ------------------------------------------------------------------
   // Weight table, worked out at elaboration. Entry d holds the Q2.14
   // kernel value at offset d / SCALE_NUM; entry zero is exactly one.
   // The sines use an eleven-term Taylor series in Q30.
   // ------------------------------------------------------------------
   logic signed [lcz_pkg::WGT_W-1:0] weight_tab [0:TAP_SPAN];

   assign weight_tab[0] = lcz_pkg::WGT_W'(16384);

   for (genvar gd = 1; gd <= TAP_SPAN; gd++) begin : g_wgt
      localparam bit [63:0] PI  = lcz_pkg::PI_Q30;
      // sin(pi * d / SCALE_NUM)
      localparam bit [63:0] A_Q  = SCALE_NUM;
      localparam bit [63:0] A_R0 = gd % (2 * SCALE_NUM);
      localparam bit        A_NG = A_R0 >= A_Q;
      localparam bit [63:0] A_R1 = A_NG ? A_R0 - A_Q : A_R0;
      localparam bit [63:0] A_R  = (2 * A_R1 > A_Q) ? A_Q - A_R1 : A_R1;
      localparam bit [63:0] A_TH = (PI * A_R) / A_Q;
      localparam bit [63:0] A_T2 = (A_TH * A_TH) >> 30;
      localparam bit [63:0] A_1  = ((A_TH * A_T2) >> 30) / 6;
      localparam bit [63:0] A_2  = ((A_1 * A_T2) >> 30) / 20;
      localparam bit [63:0] A_3  = ((A_2 * A_T2) >> 30) / 42;
      localparam bit [63:0] A_4  = ((A_3 * A_T2) >> 30) / 72;
      localparam bit [63:0] A_5  = ((A_4 * A_T2) >> 30) / 110;
      localparam bit [63:0] A_6  = ((A_5 * A_T2) >> 30) / 156;
      localparam bit [63:0] A_7  = ((A_6 * A_T2) >> 30) / 210;
      localparam bit [63:0] A_8  = ((A_7 * A_T2) >> 30) / 272;
      localparam bit [63:0] A_9  = ((A_8 * A_T2) >> 30) / 342;
      localparam bit [63:0] A_10 = ((A_9 * A_T2) >> 30) / 420;
      localparam bit [63:0] A_S  = A_TH - A_1 + A_2 - A_3 + A_4 - A_5 + A_6 - A_7
                                   + A_8 - A_9 + A_10;
      // sin(pi * d / (KERNEL_A * SCALE_NUM))
      localparam bit [63:0] B_Q  = TAP_SPAN;
      localparam bit [63:0] B_R0 = gd % (2 * TAP_SPAN);
      localparam bit        B_NG = B_R0 >= B_Q;
      localparam bit [63:0] B_R1 = B_NG ? B_R0 - B_Q : B_R0;
      localparam bit [63:0] B_R  = (2 * B_R1 > B_Q) ? B_Q - B_R1 : B_R1;
      localparam bit [63:0] B_TH = (PI * B_R) / B_Q;
      localparam bit [63:0] B_T2 = (B_TH * B_TH) >> 30;
      localparam bit [63:0] B_1  = ((B_TH * B_T2) >> 30) / 6;
      localparam bit [63:0] B_2  = ((B_1 * B_T2) >> 30) / 20;
      localparam bit [63:0] B_3  = ((B_2 * B_T2) >> 30) / 42;
      localparam bit [63:0] B_4  = ((B_3 * B_T2) >> 30) / 72;
      localparam bit [63:0] B_5  = ((B_4 * B_T2) >> 30) / 110;
      localparam bit [63:0] B_6  = ((B_5 * B_T2) >> 30) / 156;
      localparam bit [63:0] B_7  = ((B_6 * B_T2) >> 30) / 210;
      localparam bit [63:0] B_8  = ((B_7 * B_T2) >> 30) / 272;
      localparam bit [63:0] B_9  = ((B_8 * B_T2) >> 30) / 342;
      localparam bit [63:0] B_10 = ((B_9 * B_T2) >> 30) / 420;
      localparam bit [63:0] B_S  = B_TH - B_1 + B_2 - B_3 + B_4 - B_5 + B_6 - B_7
                                   + B_8 - B_9 + B_10;
      // Kernel value and rounding to Q2.14.
      localparam bit [63:0] PI2  = (PI * PI) >> 30;
      localparam bit [63:0] MAG  = (A_S * B_S) >> 30;
      localparam bit [63:0] NUM  = (MAG * KERNEL_A * SCALE_NUM * SCALE_NUM) << 14;
      localparam bit [63:0] DEN  = PI2 * gd * gd;
      localparam bit [63:0] WMAG = (NUM + DEN / 2) / DEN;
      localparam bit        NEG  = A_NG ^ B_NG;

      assign weight_tab[gd] = NEG ? -lcz_pkg::WGT_W'(WMAG) : lcz_pkg::WGT_W'(WMAG);
   end

   // Tap range of one pass. On the grid of an integer scale the single tap
   // is the source sample itself, whose offset is zero.
   function automatic lcz_pkg::range_type tap_range(
      input logic [lcz_pkg::POS_W-1:0] pos,
      input int                         limit
   );
      logic [lcz_pkg::IDX_W-1:0] fl;
      logic [lcz_pkg::POS_W-1:0] rem;
      lcz_pkg::range_type        r;
      fl  = lcz_pkg::IDX_W'((32'(pos) * 32'(RECIP)) >> RECIP_SH);
      rem = lcz_pkg::POS_W'(32'(pos) - 32'(fl) * 32'(SCALE_NUM));
      if (WHOLE_RATIO && rem == '0) begin
         r.lo = fl;
         r.hi = fl;
      end else begin
         r.lo = (32'(fl) + 32'd1 >= 32'(KERNEL_A)) ?
                lcz_pkg::IDX_W'(32'(fl) + 32'd1 - 32'(KERNEL_A)) : '0;
         r.hi = (32'(fl) + 32'(KERNEL_A) > 32'(limit - 1)) ?
                lcz_pkg::IDX_W'(limit - 1) : lcz_pkg::IDX_W'(32'(fl) + 32'(KERNEL_A));
      end
      r.d0 = lcz_pkg::D_W'($signed(32'(pos)) - $signed(32'(r.lo) * 32'(SCALE_NUM)));
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   lcz_pkg::state_type state_ff, state_in;

   logic [6:0]                    row_ff, row_in;
   logic [6:0]                    col_ff, col_in;
   logic                          bad_ff, bad_in;
   logic [lcz_pkg::IDX_W-1:0]     vi_ff, vi_in;
   logic [lcz_pkg::IDX_W-1:0]     vhi_ff, vhi_in;
   logic [lcz_pkg::IDX_W-1:0]     hcur_ff, hcur_in;
   logic [lcz_pkg::IDX_W-1:0]     hlo_ff, hlo_in;
   logic [lcz_pkg::IDX_W-1:0]     hhi_ff, hhi_in;
   logic signed [lcz_pkg::D_W-1:0] vd_ff, vd_in;
   logic signed [lcz_pkg::D_W-1:0] hd_ff, hd_in;
   logic signed [lcz_pkg::D_W-1:0] hd0_ff, hd0_in;
   logic                          tap_valid_ff, tap_valid_in;
   logic signed [lcz_pkg::WGT_W-1:0] tap_w_ff, tap_w_in;

   logic [23:0] mem [0:DEPTH-1];
   logic [23:0] mem_rd_ff;

   logic                     req_xfer;
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [ADDR_W-1:0]        mem_raddr;
   logic [23:0]              mem_wdata;
   logic signed [lcz_pkg::WGT_W-1:0] h_w, v_w, mac_w;
   logic [lcz_pkg::D_W-1:0]  h_ad, v_ad;
   logic [lcz_pkg::POS_W-1:0] rpos, cpos;
   lcz_pkg::range_type       vr, hr;
   lcz_pkg::mac_ctrl_type    mac_ctrl;
   logic [23:0]              mac_result;

   assign req_xfer = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Image store: one write port for pixel writes, one registered read port
   // that the horizontal tap loop walks along a row.
   // ------------------------------------------------------------------
   assign mem_we    = req_xfer && req_data.command == lcz_pkg::CMD_WRITE &&
                      32'(req_data.pix_row) < 32'(IN_H) && 32'(req_data.pix_col) < 32'(IN_W);
   assign mem_waddr = ADDR_W'(32'(req_data.pix_row) * 32'(IN_W) + 32'(req_data.pix_col));
   assign mem_wdata = {req_data.red_in, req_data.green_in, req_data.blue_in} & CH_MASK;
   assign mem_raddr = ADDR_W'(32'(vi_ff) * 32'(IN_W) + 32'(hcur_ff));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   // Weight lookups for the current horizontal and vertical tap offsets.
   assign h_ad = hd_ff < 0 ? lcz_pkg::D_W'(-hd_ff) : lcz_pkg::D_W'(hd_ff);
   assign v_ad = vd_ff < 0 ? lcz_pkg::D_W'(-vd_ff) : lcz_pkg::D_W'(vd_ff);
   assign h_w  = (h_ad <= lcz_pkg::D_W'(TAP_SPAN)) ? weight_tab[h_ad[TAB_W-1:0]] : '0;
   assign v_w  = (v_ad <= lcz_pkg::D_W'(TAP_SPAN)) ? weight_tab[v_ad[TAB_W-1:0]] : '0;

   assign rpos = lcz_pkg::POS_W'(32'(row_ff) * 32'(SCALE_DEN));
   assign cpos = lcz_pkg::POS_W'(32'(col_ff) * 32'(SCALE_DEN));
   assign vr   = tap_range(rpos, IN_H);
   assign hr   = tap_range(cpos, IN_W);

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lcz_pkg::ST_IDLE: begin
            if (req_xfer && req_data.command == lcz_pkg::CMD_READ) begin
               state_in = lcz_pkg::ST_SETUP;
            end
         end
         lcz_pkg::ST_SETUP: begin
            state_in = bad_in ? lcz_pkg::ST_DONE : lcz_pkg::ST_HTAP;
         end
         lcz_pkg::ST_HTAP: begin
            if (hcur_ff == hhi_ff) begin
               state_in = lcz_pkg::ST_HDRAIN;
            end
         end
         lcz_pkg::ST_HDRAIN: begin
            state_in = lcz_pkg::ST_VACC;
         end
         lcz_pkg::ST_VACC: begin
            state_in = (vi_ff == vhi_ff) ? lcz_pkg::ST_DONE : lcz_pkg::ST_HTAP;
         end
         lcz_pkg::ST_DONE: begin
            if (rsp_ready) begin
               state_in = lcz_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcz_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: counters, handshake and MAC control
   // ------------------------------------------------------------------
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      bad_in       = bad_ff;
      vi_in        = vi_ff;
      vhi_in       = vhi_ff;
      vd_in        = vd_ff;
      hcur_in      = hcur_ff;
      hlo_in       = hlo_ff;
      hhi_in       = hhi_ff;
      hd_in        = hd_ff;
      hd0_in       = hd0_ff;
      tap_valid_in = 1'b0;
      tap_w_in     = h_w;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      mac_ctrl     = '0;
      mac_w        = tap_w_ff;
      case (state_ff)
         lcz_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            row_in    = req_data.pix_row;
            col_in    = req_data.pix_col;
         end
         lcz_pkg::ST_SETUP: begin
            // Out-of-image reads skip the filter and report zeros.
            bad_in  = 32'(row_ff) >= 32'(OUT_H) || 32'(col_ff) >= 32'(OUT_W);
            vi_in   = vr.lo;
            vhi_in  = vr.hi;
            vd_in   = vr.d0;
            hlo_in  = hr.lo;
            hhi_in  = hr.hi;
            hd0_in  = hr.d0;
            hcur_in = hr.lo;
            hd_in   = hr.d0;
            mac_ctrl.hclear = 1'b1;
            mac_ctrl.vclear = 1'b1;
         end
         lcz_pkg::ST_HTAP: begin
            // Issue one store read per cycle; its weight is registered alongside
            // the read data, and both reach the MAC in the next cycle.
            tap_valid_in  = 1'b1;
            hcur_in       = hcur_ff + 1'b1;
            hd_in         = hd_ff - lcz_pkg::D_W'(SCALE_NUM);
            mac_ctrl.hacc = tap_valid_ff;
         end
         lcz_pkg::ST_HDRAIN: begin
            mac_ctrl.hacc = tap_valid_ff;
         end
         lcz_pkg::ST_VACC: begin
            // Fold the finished row result into the vertical sum.
            mac_ctrl.vacc   = 1'b1;
            mac_ctrl.hclear = 1'b1;
            mac_w           = v_w;
            vi_in           = vi_ff + 1'b1;
            vd_in           = vd_ff - lcz_pkg::D_W'(SCALE_NUM);
            hcur_in         = hlo_ff;
            hd_in           = hd0_ff;
         end
         lcz_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcz_pkg::ST_IDLE;
         tap_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_valid_ff <= tap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      bad_ff   <= bad_in;
      vi_ff    <= vi_in;
      vhi_ff   <= vhi_in;
      vd_ff    <= vd_in;
      hcur_ff  <= hcur_in;
      hlo_ff   <= hlo_in;
      hhi_ff   <= hhi_in;
      hd_ff    <= hd_in;
      hd0_ff   <= hd0_in;
      tap_w_ff <= tap_w_in;
   end

   lcz_mac u_mac (
      .clock    (clock),
      .ctrl     (mac_ctrl),
      .pix_word (mem_rd_ff),
      .weight   (mac_w),
      .result   (mac_result)
   );

   assign rsp_data.red_out   = bad_ff ? 8'd0 : mac_result[23:16] & CH_MASK[23:16];
   assign rsp_data.green_out = bad_ff ? 8'd0 : mac_result[15:8] & CH_MASK[15:8];
   assign rsp_data.blue_out  = bad_ff ? 8'd0 : mac_result[7:0] & CH_MASK[7:0];
   assign rsp_data.bad_coord = bad_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `LCZ_ASSERT_IMP(a_no_overlap, req_ready, !rsp_valid)
   `LCZ_ASSERT_NEXT(a_read_starts, req_xfer && req_data.command == lcz_pkg::CMD_READ,
                    state_ff == lcz_pkg::ST_SETUP)
   `LCZ_ASSERT_IMP(a_tap_in_loop, tap_valid_ff,
                   state_ff == lcz_pkg::ST_HTAP || state_ff == lcz_pkg::ST_HDRAIN)
   `LCZ_ASSERT_IMP(a_col_bound, state_ff == lcz_pkg::ST_HTAP, hcur_ff <= hhi_ff)

endmodule

// ----- design/lcz_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lanczos multiply-accumulate unit
// One multiplier per color lane, shared by the horizontal and vertical passes.
// ----------------------------------------------------------------------------
module lcz_mac (
   input  logic                                clock,
   input  lcz_pkg::mac_ctrl_type               ctrl,
   input  logic [23:0]                         pix_word,
   input  logic signed [lcz_pkg::WGT_W-1:0]    weight,
   output logic [23:0]                         result
);

   function automatic logic [7:0] clamp_q14(input logic signed [lcz_pkg::ACC_W-1:0] acc);
      logic signed [lcz_pkg::ACC_W-1:0] sh;
      sh = acc >>> 14;
      if (acc < 0) return 8'd0;
      if (sh > 255) return 8'd255;
      return sh[7:0];
   endfunction

   for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      logic signed [lcz_pkg::ACC_W-1:0] hacc_ff, hacc_in;
      logic signed [lcz_pkg::ACC_W-1:0] vacc_ff, vacc_in;
      logic [7:0]                       oper;
      logic signed [24:0]               prod;

      // The vertical pass multiplies a finished horizontal result.
      assign oper = ctrl.vacc ? clamp_q14(hacc_ff) : pix_word[16-8*gl +: 8];
      assign prod = $signed({1'b0, oper}) * weight;

      always_comb begin
         hacc_in = hacc_ff;
         vacc_in = vacc_ff;
         if (ctrl.hacc) begin
            hacc_in = hacc_ff + lcz_pkg::ACC_W'(prod);
         end else if (ctrl.hclear) begin
            hacc_in = '0;
         end
         if (ctrl.vclear) begin
            vacc_in = '0;
         end else if (ctrl.vacc) begin
            vacc_in = vacc_ff + lcz_pkg::ACC_W'(prod);
         end
      end

      always_ff @(posedge clock) begin
         hacc_ff <= hacc_in;
         vacc_ff <= vacc_in;
      end

      assign result[16-8*gl +: 8] = clamp_q14(vacc_ff);
   end

endmodule
